/* hw/rtl/blpg_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package blpg_pkg;

    // Per-line direction flags handed from the front end to the stepper
    typedef struct packed {
        logic x_major;   // step along x, else along y
        logic step_neg;  // minor coordinate decrements
    } blpg_dir_t;

    localparam int DIR_BITS = $bits(blpg_dir_t);

    // Guard bits on the error term above 2^COORD_BITS
    localparam int ERR_GUARD = 3;

endpackage

`default_nettype wire

/* hw/rtl/blpg_front.sv */
`timescale 1ns / 1ps
`default_nettype none

module blpg_front
    import blpg_pkg::*;
#(
    parameter int COORD_BITS = 6
) (
    input  wire logic                        in_valid,
    output logic                             in_ready,
    input  wire logic [COORD_BITS-1:0]       ax,
    input  wire logic [COORD_BITS-1:0]       ay,
    input  wire logic [COORD_BITS-1:0]       bx,
    input  wire logic [COORD_BITS-1:0]       by,
    output logic                             push,
    input  wire logic                        full,
    output blpg_dir_t                        dir,
    output logic [COORD_BITS-1:0]            lo_x,
    output logic [COORD_BITS-1:0]            lo_y,
    output logic [COORD_BITS-1:0]            dmaj,
    output logic [COORD_BITS-1:0]            dmin,
    output logic signed [COORD_BITS+ERR_GUARD-1:0] err_init
);

    logic signed [COORD_BITS:0] dx;
    logic signed [COORD_BITS:0] dy;
    logic [COORD_BITS-1:0]      adx;
    logic [COORD_BITS-1:0]      ady;
    logic                       swap;
    logic [COORD_BITS:0]        adx_w;
    logic [COORD_BITS:0]        ady_w;

    always_comb
    begin
        dx    = $signed({1'b0, bx}) - $signed({1'b0, ax});
        dy    = $signed({1'b0, by}) - $signed({1'b0, ay});
        adx_w = dx[COORD_BITS] ? $unsigned(-dx) : $unsigned(dx);
        ady_w = dy[COORD_BITS] ? $unsigned(-dy) : $unsigned(dy);
        adx   = adx_w[COORD_BITS-1:0];
        ady   = ady_w[COORD_BITS-1:0];

        dir.x_major = (ady < adx);
        swap        = dir.x_major ? dx[COORD_BITS] : dy[COORD_BITS];

        lo_x = swap ? bx : ax;
        lo_y = swap ? by : ay;
        dmaj = dir.x_major ? adx : ady;
        dmin = dir.x_major ? ady : adx;

        // minor delta seen from the lower endpoint
        if (dir.x_major)
            dir.step_neg = swap ? (dy > 0) : dy[COORD_BITS];
        else
            dir.step_neg = swap ? (dx > 0) : dx[COORD_BITS];

        err_init = $signed({{(ERR_GUARD-1){1'b0}}, dmin, 1'b0})
                 - $signed({{ERR_GUARD{1'b0}}, dmaj});
    end

    // zero-length lines are taken and dropped
    assign in_ready = !full;
    assign push     = in_valid && !full && (dmaj != '0);

endmodule

`default_nettype wire

/* hw/rtl/blpg_fifo.sv */
`timescale 1ns / 1ps
`default_nettype none

module blpg_fifo #(
    parameter int WIDTH = 8
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push,
    input  wire logic [WIDTH-1:0] wdata,
    output logic                  full,
    input  wire logic             pop,
    output logic [WIDTH-1:0]      rdata,
    output logic                  empty
);

    logic [WIDTH-1:0] mem_reg [2];
    logic             wr_ptr_reg;
    logic             wr_ptr_next;
    logic             rd_ptr_reg;
    logic             rd_ptr_next;
    logic [1:0]       count_reg;
    logic [1:0]       count_next;
    logic             do_push;
    logic             do_pop;

    assign full    = (count_reg == 2'd2);
    assign empty   = (count_reg == 2'd0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rdata   = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = do_push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_pop ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, do_push} - {1'b0, do_pop};
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem_reg[wr_ptr_reg] <= wdata;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

`default_nettype wire

/* hw/rtl/blpg_back.sv */
`timescale 1ns / 1ps
`default_nettype none

module blpg_back
    import blpg_pkg::*;
#(
    parameter int COORD_BITS = 6
) (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire logic                                  empty,
    output logic                                       pop,
    input  wire blpg_dir_t                             dir,
    input  wire logic [COORD_BITS-1:0]                 lo_x,
    input  wire logic [COORD_BITS-1:0]                 lo_y,
    input  wire logic [COORD_BITS-1:0]                 dmaj,
    input  wire logic [COORD_BITS-1:0]                 dmin,
    input  wire logic signed [COORD_BITS+ERR_GUARD-1:0] err_init,
    output logic                                       out_valid,
    input  wire logic                                  out_ready,
    output logic [COORD_BITS-1:0]                      out_x,
    output logic [COORD_BITS-1:0]                      out_y,
    output logic                                       out_last
);

    localparam int EW = COORD_BITS + ERR_GUARD;

    logic                         busy_reg;
    logic                         busy_next;
    blpg_dir_t                    dir_reg;
    logic [COORD_BITS-1:0]        maj_reg;
    logic [COORD_BITS-1:0]        min_reg;
    logic [COORD_BITS-1:0]        cnt_reg;
    logic [COORD_BITS-1:0]        dmaj_reg;
    logic [COORD_BITS-1:0]        dmin_reg;
    logic signed [EW-1:0]         err_reg;
    logic signed [EW-1:0]         err_next;
    logic [COORD_BITS-1:0]        min_next;

    logic                         ovalid_reg;
    logic                         ovalid_next;
    logic [COORD_BITS-1:0]        ox_reg;
    logic [COORD_BITS-1:0]        oy_reg;
    logic                         olast_reg;

    logic                         adv;
    logic                         is_last;
    logic signed [EW-1:0]         twice_dmin;
    logic signed [EW-1:0]         twice_dmaj;

    assign adv     = busy_reg && (!ovalid_reg || out_ready);
    assign is_last = (cnt_reg == dmaj_reg - 1'b1);
    // load the next line while the current one retires its last point
    assign pop     = !empty && (!busy_reg || (adv && is_last));

    always_comb
    begin
        twice_dmin = $signed({{(ERR_GUARD-1){1'b0}}, dmin_reg, 1'b0});
        twice_dmaj = $signed({{(ERR_GUARD-1){1'b0}}, dmaj_reg, 1'b0});
        if (err_reg > 0)
        begin
            err_next = err_reg + twice_dmin - twice_dmaj;
            min_next = dir_reg.step_neg ? min_reg - 1'b1 : min_reg + 1'b1;
        end
        else
        begin
            err_next = err_reg + twice_dmin;
            min_next = min_reg;
        end

        if (pop)
            busy_next = 1'b1;
        else if (adv && is_last)
            busy_next = 1'b0;
        else
            busy_next = busy_reg;

        if (adv)
            ovalid_next = 1'b1;
        else if (out_ready)
            ovalid_next = 1'b0;
        else
            ovalid_next = ovalid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            dir_reg  <= dir;
            maj_reg  <= dir.x_major ? lo_x : lo_y;
            min_reg  <= dir.x_major ? lo_y : lo_x;
            cnt_reg  <= '0;
            dmaj_reg <= dmaj;
            dmin_reg <= dmin;
            err_reg  <= err_init;
        end
        else if (adv)
        begin
            maj_reg <= maj_reg + 1'b1;
            min_reg <= min_next;
            cnt_reg <= cnt_reg + 1'b1;
            err_reg <= err_next;
        end

        if (adv)
        begin
            ox_reg    <= dir_reg.x_major ? maj_reg : min_reg;
            oy_reg    <= dir_reg.x_major ? min_reg : maj_reg;
            olast_reg <= is_last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg   <= 1'b0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            busy_reg   <= busy_next;
            ovalid_reg <= ovalid_next;
        end
    end

    assign out_valid = ovalid_reg;
    assign out_x     = ox_reg;
    assign out_y     = oy_reg;
    assign out_last  = olast_reg;

endmodule

`default_nettype wire

/* hw/rtl/bresenham_line_point_generator.sv */
`timescale 1ns / 1ps
`default_nettype none

// Channel  Dir  Beat contents
// s_*      in   one line: start_x, start_y, end_x, end_y
// m_*      out  one raster point: point_x, point_y; tlast marks the final point
//
// Each line is classified in the cycle it is taken and queued (two entries).
// The stepper then emits one point per cycle unless m_tready stalls it,
// max(|dx|,|dy|) beats per line (up to 2^COORD_BITS - 1); a zero-length line
// gives no beat. Lines run back to back: the next is loaded as the last point
// of the current one leaves. Reset clears the queue and the stepper. A stalled
// m side fills the queue and then holds s_tready low.
module bresenham_line_point_generator
    import blpg_pkg::*;
#(
    parameter int COORD_BITS = 6
) (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire logic                                  s_tvalid,
    output logic                                       s_tready,
    // start_x, start_y, end_x, end_y (low bits first)
    input  wire logic [((4*COORD_BITS+7)/8)*8-1:0]     s_tdata,
    output logic                                       m_tvalid,
    input  wire logic                                  m_tready,
    // point_x, point_y (low bits first), zero padded
    output logic [((2*COORD_BITS+7)/8)*8-1:0]          m_tdata,
    output logic                                       m_tlast
);

    localparam int C      = COORD_BITS;
    localparam int EW     = C + ERR_GUARD;
    localparam int DESC_W = DIR_BITS + 4*C + EW;
    localparam int OUT_W  = ((2*C+7)/8)*8;

    blpg_dir_t              f_dir;
    blpg_dir_t              b_dir;
    logic [C-1:0]           f_lo_x, f_lo_y, f_dmaj, f_dmin;
    logic [C-1:0]           b_lo_x, b_lo_y, b_dmaj, b_dmin;
    logic signed [EW-1:0]   f_err;
    logic signed [EW-1:0]   b_err;
    logic                   push, full, pop, empty;
    logic [DESC_W-1:0]      wdata;
    logic [DESC_W-1:0]      rdata;
    logic [C-1:0]           pt_x, pt_y;

    blpg_front #(.COORD_BITS(C)) u_front (
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .ax       (s_tdata[C-1:0]),
        .ay       (s_tdata[2*C-1:C]),
        .bx       (s_tdata[3*C-1:2*C]),
        .by       (s_tdata[4*C-1:3*C]),
        .push     (push),
        .full     (full),
        .dir      (f_dir),
        .lo_x     (f_lo_x),
        .lo_y     (f_lo_y),
        .dmaj     (f_dmaj),
        .dmin     (f_dmin),
        .err_init (f_err)
    );

    assign wdata = {f_dir, f_lo_x, f_lo_y, f_dmaj, f_dmin, f_err};

    blpg_fifo #(.WIDTH(DESC_W)) u_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .wdata (wdata),
        .full  (full),
        .pop   (pop),
        .rdata (rdata),
        .empty (empty)
    );

    assign {b_dir, b_lo_x, b_lo_y, b_dmaj, b_dmin, b_err} = rdata;

    blpg_back #(.COORD_BITS(C)) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .empty     (empty),
        .pop       (pop),
        .dir       (b_dir),
        .lo_x      (b_lo_x),
        .lo_y      (b_lo_y),
        .dmaj      (b_dmaj),
        .dmin      (b_dmin),
        .err_init  (b_err),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_x     (pt_x),
        .out_y     (pt_y),
        .out_last  (m_tlast)
    );

    assign m_tdata = OUT_W'({pt_y, pt_x});

endmodule

`default_nettype wire

/* bench/tb_bresenham_line_point_generator.sv */
`timescale 1ns / 1ps

module tb_bresenham_line_point_generator;

    localparam int CB  = 6;
    localparam int S_W = ((4*CB+7)/8)*8;
    localparam int M_W = ((2*CB+7)/8)*8;
    localparam int N_DIRECTED = 25;
    localparam int N_RANDOM   = 405;
    localparam int TAIL_CYCLES = 80;

    typedef struct packed {
        logic [CB-1:0] sx;
        logic [CB-1:0] sy;
        logic [CB-1:0] ex;
        logic [CB-1:0] ey;
    } line_t;

    typedef struct packed {
        logic [CB-1:0] x;
        logic [CB-1:0] y;
        logic          last;
    } point_t;

    // lit = 1: the expected points are typed in (lit_n of them, 0 or 1)
    typedef struct packed {
        line_t         ln;
        logic          lit;
        logic [1:0]    lit_n;
        logic [CB-1:0] lit_x;
        logic [CB-1:0] lit_y;
    } row_t;

    logic           clk = 1'b0;
    logic           rst_n;
    logic           s_tvalid;
    logic           s_tready;
    logic [S_W-1:0] s_tdata;    // start_x, start_y, end_x, end_y
    logic           m_tvalid;
    logic           m_tready = 1'b0;
    logic [M_W-1:0] m_tdata;    // point_x, point_y, zero pad
    logic           m_tlast;

    point_t exp_points[$];
    row_t   dir_rows[N_DIRECTED];
    bit     no_idle = 1'b0;
    int     n_errors = 0;
    int     n_lines = 0;
    int     n_zero = 0;
    int     n_points = 0;

    bresenham_line_point_generator #(.COORD_BITS(CB)) uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    always #5 clk = ~clk;

    task automatic note_mismatch(input string msg);
        n_errors++;
        if (n_errors <= 10)
            $display("[%0t] mismatch: %s", $time, msg);
    endtask

    // Integer Bresenham walk; queues the raster points of one line.
    function automatic void predict_line(input line_t ln);
        int ax, ay, bx, by, dx, dy, adx, ady;
        int lox, loy, hix, hiy, dmaj, dmin, stp, err, minor, px, py, i;
        bit xmaj;
        point_t p;
        ax = ln.sx;
        ay = ln.sy;
        bx = ln.ex;
        by = ln.ey;
        dx = bx - ax;
        dy = by - ay;
        adx = dx < 0 ? -dx : dx;
        ady = dy < 0 ? -dy : dy;
        xmaj = ady < adx;
        if ((xmaj && dx < 0) || (!xmaj && dy < 0))
        begin
            lox = bx; loy = by; hix = ax; hiy = ay;
        end
        else
        begin
            lox = ax; loy = ay; hix = bx; hiy = by;
        end
        if (xmaj)
        begin
            dmaj = hix - lox;
            dmin = hiy - loy;
            minor = loy;
        end
        else
        begin
            dmaj = hiy - loy;
            dmin = hix - lox;
            minor = lox;
        end
        stp = 1;
        if (dmin < 0)
        begin
            stp = -1;
            dmin = -dmin;
        end
        err = 2 * dmin - dmaj;
        for (i = 0; i < dmaj; i++)
        begin
            px = xmaj ? lox + i : minor;
            py = xmaj ? minor : loy + i;
            p.x = px[CB-1:0];
            p.y = py[CB-1:0];
            p.last = (i == dmaj - 1);
            exp_points.insert(exp_points.size(), p);
            // minor axis moves only on a strictly positive error term
            if (err > 0)
            begin
                minor += stp;
                err += 2 * (dmin - dmaj);
            end
            else
            begin
                err += 2 * dmin;
            end
        end
    endfunction

    // Holds the beat until accepted; returns at the accepting rising edge.
    task automatic send_line(input line_t ln);
        @(negedge clk);
        while (!no_idle && $urandom_range(0, 99) < 36)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {ln.ey, ln.ex, ln.sy, ln.sx};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        n_lines++;
        if (ln.sx == ln.ex && ln.sy == ln.ey)
            n_zero++;
    endtask

    function automatic line_t random_line();
        line_t ln;
        int kind, a, b, c;
        kind = $urandom_range(0, 99);
        a = $urandom_range(0, 63);
        b = $urandom_range(0, 63);
        c = $urandom_range(0, 63);
        ln.sx = $urandom_range(0, 63);
        ln.sy = $urandom_range(0, 63);
        ln.ex = $urandom_range(0, 63);
        ln.ey = $urandom_range(0, 63);
        if (kind < 55)
        begin
            // fully random endpoints
        end
        else if (kind < 75)
        begin
            // short line: low bits of the far end flipped
            ln.ex = ln.sx ^ $urandom_range(0, 7);
            ln.ey = ln.sy ^ $urandom_range(0, 7);
        end
        else if (kind < 88)
        begin
            case ($urandom_range(0, 3))
                0: ln = {a[CB-1:0], c[CB-1:0], b[CB-1:0], c[CB-1:0]};
                1: ln = {c[CB-1:0], a[CB-1:0], c[CB-1:0], b[CB-1:0]};
                2: ln = {a[CB-1:0], a[CB-1:0], b[CB-1:0], b[CB-1:0]};
                default: ln = {a[CB-1:0], 6'(63 - a), b[CB-1:0], 6'(63 - b)};
            endcase
        end
        else if (kind < 94)
        begin
            ln.ex = ln.sx;
            ln.ey = ln.sy;
        end
        else
        begin
            ln.sx = $urandom_range(0, 1) ? 63 : 0;
            ln.sy = $urandom_range(0, 1) ? 63 : 0;
            ln.ex = $urandom_range(0, 1) ? 63 : 0;
            ln.ey = $urandom_range(0, 1) ? 63 : 0;
        end
        return ln;
    endfunction

    always @(negedge clk)
        m_tready <= no_idle || ($urandom_range(0, 99) >= 36);

    always @(posedge clk)
    begin
        point_t got, want;
        if (rst_n && m_tvalid && m_tready)
        begin
            got.x = m_tdata[CB-1:0];
            got.y = m_tdata[2*CB-1:CB];
            got.last = m_tlast;
            n_points++;
            if (exp_points.size() == 0)
            begin
                note_mismatch($sformatf("unexpected point (%0d,%0d) last=%0b",
                                        got.x, got.y, got.last));
            end
            else
            begin
                want = exp_points.pop_front();
                if (got.x !== want.x)
                    note_mismatch($sformatf("point_x exp %0d got %0d", want.x, got.x));
                if (got.y !== want.y)
                    note_mismatch($sformatf("point_y exp %0d got %0d", want.y, got.y));
                if (got.last !== want.last)
                    note_mismatch($sformatf("last exp %0b got %0b", want.last, got.last));
            end
        end
    end

    initial
    begin
        #10_000_000;
        $display("FAIL bresenham_line_point_generator");
        $finish;
    end

    initial
    begin
        point_t p;
        line_t  ln;
        int     k;
        rst_n    = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;

        //            sx  sy  ex  ey   lit n  x  y
        dir_rows = '{
            '{'{ 5,  5,  5,  5}, 1, 0, 0, 0},     // zero length
            '{'{ 0,  0,  0,  0}, 1, 0, 0, 0},
            '{'{63, 63, 63, 63}, 1, 0, 0, 0},
            '{'{ 0,  0,  1,  0}, 1, 1, 0, 0},     // single point, x major
            '{'{ 1,  0,  0,  0}, 1, 1, 0, 0},     // backwards, swapped
            '{'{ 0,  0,  0,  1}, 1, 1, 0, 0},
            '{'{ 0,  1,  0,  0}, 1, 1, 0, 0},
            '{'{ 0,  0,  1,  1}, 1, 1, 0, 0},     // diagonal steps along y
            '{'{ 0,  0, 63,  0}, 0, 0, 0, 0},
            '{'{63,  0,  0,  0}, 0, 0, 0, 0},
            '{'{ 0,  0,  0, 63}, 0, 0, 0, 0},
            '{'{ 0, 63,  0,  0}, 0, 0, 0, 0},
            '{'{ 0,  0, 63, 63}, 0, 0, 0, 0},
            '{'{63,  0,  0, 63}, 0, 0, 0, 0},     // minor axis decrements
            '{'{ 0, 63, 63,  0}, 0, 0, 0, 0},
            '{'{ 0,  0, 63, 62}, 0, 0, 0, 0},
            '{'{63, 62,  0,  0}, 0, 0, 0, 0},
            '{'{ 0,  0, 62, 63}, 0, 0, 0, 0},
            '{'{10, 20, 40,  5}, 0, 0, 0, 0},
            '{'{40,  5, 10, 20}, 0, 0, 0, 0},
            '{'{ 5, 40, 20, 10}, 0, 0, 0, 0},
            '{'{ 0,  0,  2,  1}, 0, 0, 0, 0},     // error term hits exactly zero
            '{'{ 0,  0,  4,  2}, 0, 0, 0, 0},
            '{'{42, 21, 21, 42}, 0, 0, 0, 0},
            '{'{21, 42, 42, 21}, 0, 0, 0, 0}
        };

        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        for (k = 0; k < N_DIRECTED; k++)
        begin
            send_line(dir_rows[k].ln);
            if (!dir_rows[k].lit)
            begin
                predict_line(dir_rows[k].ln);
            end
            else if (dir_rows[k].lit_n == 1)
            begin
                p.x = dir_rows[k].lit_x;
                p.y = dir_rows[k].lit_y;
                p.last = 1'b1;
                exp_points.insert(exp_points.size(), p);
            end
        end

        for (k = 0; k < N_RANDOM; k++)
        begin
            no_idle = (k >= 100 && k < 180);
            if (k == 250)
            begin
                // let the stepper drain completely before the next line
                @(negedge clk);
                s_tvalid <= 1'b0;
                while (exp_points.size() != 0)
                    @(posedge clk);
            end
            ln = random_line();
            send_line(ln);
            predict_line(ln);
        end
        no_idle = 1'b0;

        @(negedge clk);
        s_tvalid <= 1'b0;
        while (exp_points.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("Sent %0d lines (%0d zero length, axis, diagonal, short and corner cases).",
                 n_lines, n_zero);
        $display("Checked %0d points; %0d mismatches.", n_points, n_errors);
        if (n_errors == 0 && exp_points.size() == 0)
            $display("PASS bresenham_line_point_generator");
        else
            $display("FAIL bresenham_line_point_generator");
        $finish;
    end

endmodule

/* filelist.f */
hw/rtl/blpg_pkg.sv
hw/rtl/blpg_front.sv
hw/rtl/blpg_fifo.sv
hw/rtl/blpg_back.sv
hw/rtl/bresenham_line_point_generator.sv
bench/tb_bresenham_line_point_generator.sv
